>>> hdl/bsc_pkg.sv
// Shared types, constants and multiply helpers for the barometer sample compensation core.
package bsc_pkg;

  localparam int RawW    = 20;
  localparam int TrimW   = 48;
  localparam int TempW   = 32;
  localparam int PressW  = 32;
  localparam int DataW   = 64;
  localparam int CfgIdxW = 8;

  localparam int TempOffset = 128000;
  localparam int PressFull  = 1048576;
  localparam int DivScale   = 3125;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_TRIM  = 8'd0,
    CFG_PRESS_LOW  = 8'd1,
    CFG_PRESS_MID  = 8'd2,
    CFG_PRESS_HIGH = 8'd3
  } bsc_cfg_e;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } bsc_sample_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature_centi;
    logic [PressW-1:0]       pressure_q24_8;
    logic                    pressure_valid;
  } bsc_result_t;

  // Partial products of a 64-bit word times a 17-bit signed coefficient.
  typedef struct packed {
    logic [49:0] lo;
    logic [31:0] hi;
  } bsc_part_t;

  function automatic bsc_part_t bsc_mul_split(input logic [63:0] x,
                                              input logic signed [16:0] k);
    logic signed [49:0] lo;
    logic [31:0]        kx;
    bsc_part_t          r;
    lo   = $signed({1'b0, x[31:0]}) * k;
    kx   = 32'(k);
    r.lo = lo;
    r.hi = x[63:32] * kx;
    return r;
  endfunction

  // Low 64 bits of the full product, from its two partial products.
  function automatic logic [63:0] bsc_mul_join(input bsc_part_t p);
    return {{14{p.lo[49]}}, p.lo} + {p.hi, 32'b0};
  endfunction

endpackage

>>> hdl/bsc_sdiv.sv
// Pipelined signed divider, truncating toward zero, one quotient bit per stage.
module bsc_sdiv import bsc_pkg::*; #(
  parameter int Width = DataW,
  parameter int SideW = TempW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  input  logic [SideW-1:0] side_i,
  output logic             out_valid_o,
  output logic [Width-1:0] quotient_o,
  output logic             zero_o,
  output logic [SideW-1:0] side_o
);

  logic [Width-1:0] rem_q  [Width+1];
  logic [Width-1:0] quo_q  [Width+1];
  logic [Width-1:0] dvs_q  [Width+1];
  logic             neg_q  [Width+1];
  logic             zero_q [Width+1];
  logic [SideW-1:0] side_q [Width+1];
  logic [Width+1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Width:0], in_valid_i};
    end
  end

  // Operands are made positive first; the sign is restored at the end.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    quo_q[0]  <= dividend_i[Width-1] ? (Width'(0) - dividend_i) : dividend_i;
    dvs_q[0]  <= divisor_i[Width-1] ? (Width'(0) - divisor_i) : divisor_i;
    neg_q[0]  <= dividend_i[Width-1] ^ divisor_i[Width-1];
    zero_q[0] <= (divisor_i == '0);
    side_q[0] <= side_i;
  end

  for (genvar k = 1; k <= Width; k++) begin : g_step
    logic [Width:0] trial;
    logic [Width:0] diff;
    logic           ge;
    assign trial = {rem_q[k-1], quo_q[k-1][Width-1]};
    assign diff  = trial - {1'b0, dvs_q[k-1]};
    assign ge    = (trial >= {1'b0, dvs_q[k-1]});
    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[Width-1:0] : trial[Width-1:0];
      quo_q[k]  <= {quo_q[k-1][Width-2:0], ge};
      dvs_q[k]  <= dvs_q[k-1];
      neg_q[k]  <= neg_q[k-1];
      zero_q[k] <= zero_q[k-1];
      side_q[k] <= side_q[k-1];
    end
  end

  logic [Width-1:0] quotient_q;
  logic             zero_out_q;
  logic [SideW-1:0] side_out_q;

  always_ff @(posedge clk_i) begin
    quotient_q <= neg_q[Width] ? (Width'(0) - quo_q[Width]) : quo_q[Width];
    zero_out_q <= zero_q[Width];
    side_out_q <= side_q[Width];
  end

  assign out_valid_o = vld_q[Width+1];
  assign quotient_o  = quotient_q;
  assign zero_o      = zero_out_q;
  assign side_o      = side_out_q;

  // Every quotient leaves exactly the pipeline depth after its operands came in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(in_valid_i, Width + 2))
    else $error("divider output without matching input");

endmodule

>>> hdl/barometer_sample_compensation_core.sv
// Top level of the barometer sample compensation core: trim registers and the full pipeline.
//
// Usage: write the four 48-bit trim registers through the configuration channel
// (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) while no sample is in flight.
// cfg_ready_o is always high; an index outside the four registers is dropped.
// A sample beat is taken at every rising edge with start_i high and busy_o low.
// busy_o never rises, so one raw temperature/pressure pair enters every cycle.
// Each sample gives one result beat on result_o, marked by result_valid_o for
// exactly one cycle, after the sample has gone through every stage. Throughput
// is one beat per cycle. The pipeline is the divider, whose 64 stages each
// produce one quotient bit, plus 11 stages of temperature and denominator
// arithmetic before it and 6 stages of pressure correction after it.
// The receiver cannot hold results off; it must take each beat when shown.
// Reset clears the trim registers to zero and drops every sample in flight.
// A zero denominator gives pressure 0 with pressure_valid low; the
// temperature in that beat is still correct.
module barometer_sample_compensation_core import bsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  bsc_sample_t         sample_i,
  output logic                result_valid_o,
  output bsc_result_t         result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [TrimW-1:0]    cfg_data_i
);

  localparam int FrontDepth = 11;
  localparam int PostDepth  = 6;
  localparam int Latency    = FrontDepth + DataW + 2 + PostDepth;

  // The pipeline never stalls, so both channels are always open.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic accept;
  assign accept = start_i && !busy_o;

  // Trim registers. The user must change them only while the pipeline is empty;
  // the block does not enforce this. Every stage reads the coefficients straight from them.
  logic [TrimW-1:0] temp_trim_q, press_low_q, press_mid_q, press_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q  <= '0;
      press_low_q  <= '0;
      press_mid_q  <= '0;
      press_high_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (bsc_cfg_e'(cfg_index_i))
        CFG_TEMP_TRIM:  temp_trim_q  <= cfg_data_i;
        CFG_PRESS_LOW:  press_low_q  <= cfg_data_i;
        CFG_PRESS_MID:  press_mid_q  <= cfg_data_i;
        CFG_PRESS_HIGH: press_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [15:0]        t1;
  logic [31:0]        t2x, t3x;
  logic signed [16:0] p1k, p2k, p3k, p4k, p5k, p6k, p7k, p8k, p9k, scale_k;

  assign t1      = temp_trim_q[15:0];
  assign t2x     = 32'($signed(temp_trim_q[31:16]));
  assign t3x     = 32'($signed(temp_trim_q[47:32]));
  assign p1k     = $signed({1'b0, press_low_q[15:0]});
  assign p2k     = 17'($signed(press_low_q[31:16]));
  assign p3k     = 17'($signed(press_low_q[47:32]));
  assign p4k     = 17'($signed(press_mid_q[15:0]));
  assign p5k     = 17'($signed(press_mid_q[31:16]));
  assign p6k     = 17'($signed(press_mid_q[47:32]));
  assign p7k     = 17'($signed(press_high_q[15:0]));
  assign p8k     = 17'($signed(press_high_q[31:16]));
  assign p9k     = 17'($signed(press_high_q[47:32]));
  assign scale_k = 17'(DivScale);

  // Valid bits of the stages ahead of the divider.
  logic [FrontDepth-1:0] fv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      fv_q <= {fv_q[FrontDepth-2:0], accept};
    end
  end

  // Temperature path, all arithmetic wraps at 32 bits.
  logic [31:0]        d3_q, d4_q, m1_q, m2_q, v1_q, m3_q, fine_q, m2_sh;
  logic [RawW-1:0]    adcp_q [8];
  logic [31:0]        temp_q [7];
  logic signed [32:0] a_q;
  logic signed [65:0] aa_full;
  logic [63:0]        aa_q;
  logic signed [49:0] ap5_q [2];
  logic signed [49:0] ap2_q [2];
  bsc_part_t          aap6_q, aap3_q, sp1_q, n3_q;
  logic [63:0]        b_q, a2_q, n0_q, num_q;
  logic [63:0]        den_q [2];
  logic [20:0]        pp;

  assign m2_sh   = $signed(m2_q) >>> 12;
  assign aa_full = a_q * a_q;
  assign pp      = 21'(PressFull) - {1'b0, adcp_q[7]};

  always_ff @(posedge clk_i) begin
    // Stage 1: offsets against T1.
    d3_q      <= {15'b0, sample_i.raw_temperature[RawW-1:3]} - {15'b0, t1, 1'b0};
    d4_q      <= {16'b0, sample_i.raw_temperature[RawW-1:4]} - {16'b0, t1};
    adcp_q[0] <= sample_i.raw_pressure;
    for (int i = 1; i < 8; i++) begin
      adcp_q[i] <= adcp_q[i-1];
    end
    // Stage 2 and 3: the two temperature products.
    m1_q   <= d3_q * t2x;
    m2_q   <= d4_q * d4_q;
    v1_q   <= $signed(m1_q) >>> 11;
    m3_q   <= m2_sh * t3x;
    // Stage 4: fine temperature.
    fine_q <= v1_q + 32'($signed(m3_q) >>> 14);
    // Stage 5: scaled temperature and the pressure offset variable.
    temp_q[0] <= $signed(fine_q * 32'd5 + 32'd128) >>> 8;
    for (int i = 1; i < 7; i++) begin
      temp_q[i] <= temp_q[i-1];
    end
    a_q <= $signed({fine_q[31], fine_q}) - 33'(TempOffset);
    // Stage 6: square and first-order products.
    aa_q     <= aa_full[63:0];
    ap5_q[0] <= a_q * p5k;
    ap2_q[0] <= a_q * p2k;
    // Stage 7: square times P6 and P3 as partial products.
    aap6_q   <= bsc_mul_split(aa_q, p6k);
    aap3_q   <= bsc_mul_split(aa_q, p3k);
    ap5_q[1] <= ap5_q[0];
    ap2_q[1] <= ap2_q[0];
    // Stage 8: the two polynomial sums.
    b_q  <= bsc_mul_join(aap6_q) + (64'(ap5_q[1]) << 17) + (64'(p4k) << 35);
    a2_q <= 64'($signed(bsc_mul_join(aap3_q)) >>> 8) + (64'(ap2_q[1]) << 12);
    // Stage 9: denominator product and numerator base.
    sp1_q <= bsc_mul_split((64'd1 << 47) + a2_q, p1k);
    n0_q  <= ({43'b0, pp} << 31) - b_q;
    // Stage 10 and 11: denominator and scaled numerator.
    den_q[0] <= $signed(bsc_mul_join(sp1_q)) >>> 33;
    n3_q     <= bsc_mul_split(n0_q, scale_k);
    den_q[1] <= den_q[0];
    num_q    <= bsc_mul_join(n3_q);
  end

  logic        dv;
  logic [63:0] dq;
  logic        dzero;
  logic [31:0] dtemp;

  bsc_sdiv #(
    .Width (DataW),
    .SideW (TempW)
  ) u_sdiv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fv_q[FrontDepth-1]),
    .dividend_i  (num_q),
    .divisor_i   (den_q[1]),
    .side_i      (temp_q[6]),
    .out_valid_o (dv),
    .quotient_o  (dq),
    .zero_o      (dzero),
    .side_o      (dtemp)
  );

  // Values that ride along the correction stages.
  typedef struct packed {
    logic [63:0] q;
    logic [63:0] ph;
    logic [63:0] c2;
    logic        zero;
    logic [31:0] temp;
  } post_t;

  logic [PostDepth-1:0] pv_q;
  post_t                po_q [5];
  bsc_part_t            q8_q, x9_q;
  logic [63:0]          x_q, ll_q, c1_q, psum, pres;
  logic [31:0]          lh_q, hl_q;
  bsc_result_t          result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      pv_q <= {pv_q[PostDepth-2:0], dv};
    end
  end

  assign psum = po_q[4].q + c1_q + po_q[4].c2;
  assign pres = 64'($signed(psum) >>> 8) + (64'(p7k) << 4);

  always_ff @(posedge clk_i) begin
    // Stage 1: shifted quotient and quotient times P8.
    po_q[0].q    <= dq;
    po_q[0].ph   <= $signed(dq) >>> 13;
    po_q[0].c2   <= '0;
    po_q[0].zero <= dzero;
    po_q[0].temp <= dtemp;
    q8_q         <= bsc_mul_split(dq, p8k);
    // Stage 2: P9 times the shifted quotient, second correction term.
    po_q[1].q    <= po_q[0].q;
    po_q[1].ph   <= po_q[0].ph;
    po_q[1].c2   <= $signed(bsc_mul_join(q8_q)) >>> 19;
    po_q[1].zero <= po_q[0].zero;
    po_q[1].temp <= po_q[0].temp;
    x9_q         <= bsc_mul_split(po_q[0].ph, p9k);
    // Stage 3 to 5: times the shifted quotient again, as 32-bit pieces.
    po_q[2] <= po_q[1];
    x_q     <= bsc_mul_join(x9_q);
    po_q[3] <= po_q[2];
    ll_q    <= x_q[31:0] * po_q[2].ph[31:0];
    lh_q    <= x_q[31:0] * po_q[2].ph[63:32];
    hl_q    <= x_q[63:32] * po_q[2].ph[31:0];
    po_q[4] <= po_q[3];
    c1_q    <= $signed(ll_q + {lh_q + hl_q, 32'b0}) >>> 25;
    // Stage 6: final sum and result register.
    result_q.temperature_centi <= $signed(po_q[4].temp);
    result_q.pressure_q24_8    <= po_q[4].zero ? '0 : pres[31:0];
    result_q.pressure_valid    <= !po_q[4].zero;
  end

  assign result_valid_o = pv_q[PostDepth-1];
  assign result_o       = result_q;

  // A result beat always traces back to a sample taken the full pipeline depth before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, Latency))
    else $error("result beat without a sample");

  // A result beat follows the divider output by the correction depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(dv, PostDepth))
    else $error("result beat out of step with the divider");

  // A result flagged invalid carries zero pressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.pressure_valid) |-> (result_o.pressure_q24_8 == '0))
    else $error("invalid pressure not zeroed");

endmodule

>>> bench/barometer_sample_compensation_checker.sv
// Scoreboard for the barometer sample compensation core: predicts and compares results.
module barometer_sample_compensation_checker import bsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  bsc_sample_t        sample_i,
  input  logic               result_valid_i,
  input  bsc_result_t        result_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TrimW-1:0]   cfg_data_i,
  output int                 mismatch_count_o,
  output int                 pending_o
);

  logic [TrimW-1:0] temp_trim, press_low, press_mid, press_high;
  bsc_result_t      expected_readings[$];

  // Sign-extends one 16-bit trim field to 64 bits.
  function automatic logic [63:0] trim_s64(input logic [15:0] f);
    return {{48{f[15]}}, f};
  endfunction

  // Signed 64-bit quotient, truncated toward zero, wrapping on overflow.
  function automatic logic [63:0] quotient_trunc(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] un, ud, q;
    un = num[63] ? -num : num;
    ud = den[63] ? -den : den;
    q  = un / ud;
    return (num[63] != den[63]) ? -q : q;
  endfunction

  function automatic bsc_result_t compensate_reading(input bsc_sample_t s);
    logic [31:0] adc_t, t1, t2, t3, d3, v1, d4, sq, v2, fine;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, p, ph, c1, c2;
    bsc_result_t r;
    adc_t = {12'b0, s.raw_temperature};
    t1 = {16'b0, temp_trim[15:0]};
    t2 = {{16{temp_trim[31]}}, temp_trim[31:16]};
    t3 = {{16{temp_trim[47]}}, temp_trim[47:32]};
    p1 = {48'b0, press_low[15:0]};
    p2 = trim_s64(press_low[31:16]);
    p3 = trim_s64(press_low[47:32]);
    p4 = trim_s64(press_mid[15:0]);
    p5 = trim_s64(press_mid[31:16]);
    p6 = trim_s64(press_mid[47:32]);
    p7 = trim_s64(press_high[15:0]);
    p8 = trim_s64(press_high[31:16]);
    p9 = trim_s64(press_high[47:32]);

    // Temperature path: everything wraps at 32 bits.
    d3   = (adc_t >> 3) - (t1 << 1);
    v1   = $signed(d3 * t2) >>> 11;
    d4   = (adc_t >> 4) - t1;
    sq   = $signed(d4 * d4) >>> 12;
    v2   = $signed(sq * t3) >>> 14;
    fine = v1 + v2;
    r.temperature_centi = $signed(fine * 32'd5 + 32'd128) >>> 8;

    // Pressure path: everything wraps at 64 bits.
    a = {{32{fine[31]}}, fine} - 64'(TempOffset);
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = 64'($signed(a * a * p3) >>> 8) + ((a * p2) << 12);
    a = $signed(((64'd1 << 47) + a) * p1) >>> 33;

    r.pressure_q24_8 = '0;
    r.pressure_valid = 1'b0;
    if (a != 64'd0) begin
      p  = 64'(PressFull) - {44'b0, s.raw_pressure};
      p  = quotient_trunc(((p << 31) - b) * 64'(DivScale), a);
      ph = $signed(p) >>> 13;
      c1 = $signed(p9 * ph * ph) >>> 25;
      c2 = $signed(p8 * p) >>> 19;
      p  = 64'($signed(p + c1 + c2) >>> 8) + (p7 << 4);
      r.pressure_q24_8 = p[31:0];
      r.pressure_valid = 1'b1;
    end
    return r;
  endfunction

  assign pending_o = expected_readings.size();

  always @(posedge clk_i or negedge rst_ni) begin
    bsc_result_t exp_r;
    if (!rst_ni) begin
      temp_trim  <= '0;
      press_low  <= '0;
      press_mid  <= '0;
      press_high <= '0;
      expected_readings.delete();
      mismatch_count_o = 0;
    end else begin
      if (result_valid_i) begin
        if (expected_readings.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("Unexpected result beat: %p", result_i);
        end else begin
          exp_r = expected_readings.pop_front();
          if (exp_r !== result_i) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("Mismatch: expected temp %0d press %h valid %b, got temp %0d press %h valid %b",
                       exp_r.temperature_centi, exp_r.pressure_q24_8, exp_r.pressure_valid,
                       result_i.temperature_centi, result_i.pressure_q24_8,
                       result_i.pressure_valid);
          end
        end
      end
      if (start_i && !busy_i)
        expected_readings.push_back(compensate_reading(sample_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TEMP_TRIM:  temp_trim  <= cfg_data_i;
          CFG_PRESS_LOW:  press_low  <= cfg_data_i;
          CFG_PRESS_MID:  press_mid  <= cfg_data_i;
          CFG_PRESS_HIGH: press_high <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> bench/barometer_sample_compensation_core_tb.sv
// Testbench top for the barometer sample compensation core: stimulus and verdict.
module barometer_sample_compensation_core_tb;
  import bsc_pkg::*;

  // The drain wait allows a margin on the time from a sample to its result.
  localparam int DrainCycles = 100;
  localparam int CycleLimit  = 200000;
  localparam int NumPhases   = 9;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  bsc_sample_t        sample_i;
  logic               result_valid_o;
  bsc_result_t        result_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [TrimW-1:0]   cfg_data_i;
  int                 mismatches;
  int                 outstanding;
  int                 cycle_count = 0;
  bit                 allow_gaps;

  barometer_sample_compensation_core uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .sample_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  barometer_sample_compensation_checker scoreboard (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .sample_i,
    .result_valid_i(result_valid_o), .result_i(result_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .mismatch_count_o(mismatches), .pending_o(outstanding)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes or results stop coming.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Writes one trim register. The channel's valid is left high on return, so a
  // back-to-back write keeps it up; the caller lowers it once a batch is done.
  task automatic write_trim(input logic [CfgIdxW-1:0] idx, input logic [TrimW-1:0] value);
    while (allow_gaps && $urandom_range(99) < 23) begin
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_trims(input logic [TrimW-1:0] tt, input logic [TrimW-1:0] pl,
                            input logic [TrimW-1:0] pm, input logic [TrimW-1:0] ph);
    write_trim(CFG_TEMP_TRIM, tt);
    write_trim(CFG_PRESS_LOW, pl);
    write_trim(CFG_PRESS_MID, pm);
    write_trim(CFG_PRESS_HIGH, ph);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one sample beat and returns at the edge that takes it. Start stays
  // high afterwards so consecutive beats can go in on consecutive cycles.
  task automatic send_sample(input logic [RawW-1:0] raw_t, input logic [RawW-1:0] raw_p);
    while (allow_gaps && $urandom_range(99) < 23) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i  <= 1'b1;
    sample_i <= '{raw_temperature: raw_t, raw_pressure: raw_p};
    do @(posedge clk_i); while (busy_o);
  endtask

  // Sends the field extremes and a few bit patterns under the current trims.
  task automatic send_corner_samples();
    logic [RawW-1:0] pats[6];
    pats = '{20'h00000, 20'hFFFFF, 20'h55555, 20'hAAAAA, 20'h80000, 20'h7FFFF};
    foreach (pats[i]) send_sample(pats[i], pats[5 - i]);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
  endtask

  // Mostly readings in the range a working sensor produces, the rest anything at all.
  task automatic send_random_samples(input int count);
    logic [RawW-1:0] raw_t, raw_p;
    repeat (count) begin
      if ($urandom_range(99) < 60) begin
        raw_t = RawW'($urandom_range(600000, 420000));
        raw_p = RawW'($urandom_range(500000, 250000));
      end else begin
        raw_t = RawW'($urandom);
        raw_p = RawW'($urandom);
      end
      send_sample(raw_t, raw_p);
    end
  endtask

  // Lets every outstanding result come back and the pipeline empty before the
  // trims change.
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [TrimW-1:0] random_trim();
    return {16'($urandom), 32'($urandom)};
  endfunction

  initial begin
    logic [TrimW-1:0] tt, pl, pm, ph;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    sample_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    allow_gaps  = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With all trims at their reset value of zero, the denominator is zero, so
    // every beat must carry pressure 0 with the valid flag low.
    send_corner_samples();
    send_random_samples(20);
    drain();

    for (int phase = 1; phase < NumPhases; phase++) begin
      // One phase runs entirely without gaps on either channel.
      allow_gaps = (phase != 4);
      case (phase)
        1, 4: begin
          // Typical factory trims of a real part.
          tt = {16'hFC18, 16'd26435, 16'd27504};
          pl = {16'd3024, 16'hD643, 16'd36477};
          pm = {16'hFFF9, 16'd140, 16'd2855};
          ph = {16'd6000, 16'hC6F8, 16'd15500};
        end
        2: begin
          tt = '1; pl = '1; pm = '1; ph = '1;
        end
        3: begin
          // Most negative signed fields, unsigned fields at their top.
          tt = 48'h8000_8000_FFFF;
          pl = 48'h8000_8000_FFFF;
          pm = 48'h8000_8000_8000;
          ph = 48'h8000_8000_8000;
        end
        5: begin
          // Largest positive signed fields, unsigned fields at one.
          tt = 48'h7FFF_7FFF_0001;
          pl = 48'h7FFF_7FFF_0001;
          pm = 48'h7FFF_7FFF_7FFF;
          ph = 48'h7FFF_7FFF_7FFF;
        end
        default: begin
          tt = random_trim(); pl = random_trim(); pm = random_trim(); ph = random_trim();
        end
      endcase
      load_trims(tt, pl, pm, ph);
      // An index past the last register must leave the trims alone.
      if (phase == NumPhases - 1) begin
        write_trim(CfgIdxW'(CFG_PRESS_HIGH) + 1'b1, random_trim());
        write_trim('1, random_trim());
        cfg_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      send_corner_samples();
      send_random_samples(phase == 4 ? 260 : 210);
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> barometer_sample_compensation_core.f
hdl/bsc_pkg.sv
hdl/bsc_sdiv.sv
hdl/barometer_sample_compensation_core.sv
bench/barometer_sample_compensation_checker.sv
bench/barometer_sample_compensation_core_tb.sv
